### src/bll_pkg.sv
// types, codes and defaults shared by the linked list engine
package bll_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [2:0] {
      KIND_INS_HEAD = 3'd0,
      KIND_INS_MID  = 3'd1,
      KIND_INS_TAIL = 3'd2,
      KIND_SEARCH   = 3'd3,
      KIND_REMOVE   = 3'd4,
      KIND_LIST     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_WALK_INS,
      ST_LINK_PREV,
      ST_WALK_FIND,
      ST_FREE_NODE,
      ST_LIST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [5:0]         position;
      logic signed [31:0] element;
      logic [6:0]         count;
      logic               is_last;
   } rsp_type;

endpackage

### src/bll_ram.sv
// generic single write port ram with registered read
module bll_ram
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bll_seq.sv
// list sequencer: walks the node memories and builds result words
module bll_seq
   import bll_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   localparam int IW = $clog2(CAPACITY + 1),
   localparam int AW = $clog2(CAPACITY)
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic [AW-1:0]      rd_addr,
   input  logic [IW-1:0]      link_rdata,
   input  logic [31:0]        value_rdata,
   output logic               link_we,
   output logic [AW-1:0]      link_waddr,
   output logic [IW-1:0]      link_wdata,
   output logic               value_we,
   output logic [AW-1:0]      value_waddr,
   output logic [31:0]        value_wdata,
   input  logic               can_load,
   output logic               out_load,
   output rsp_type            out_word
);

   localparam logic [IW-1:0] END_MARK = IW'(CAPACITY);
   localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);

   state_type          state_ff, state_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      free_ff, free_in;
   logic [IW-1:0]      fresh_ff, fresh_in;
   logic [IW-1:0]      count_ff, count_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [IW-1:0]      prev_ff, prev_in;
   logic [IW-1:0]      node_ff, node_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      tgt_ff, tgt_in;
   logic [2:0]         kind_ff, kind_in;
   logic signed [31:0] value_ff, value_in;
   rsp_type            res_ff, res_in;
   logic               accept;
   logic               is_insert;
   logic               match;
   logic               list_last;
   logic [IW-1:0]      mid_pos;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_insert = (req_data.kind == KIND_INS_HEAD) || (req_data.kind == KIND_INS_MID)
                      || (req_data.kind == KIND_INS_TAIL);
   assign match     = (value_rdata == value_ff);
   assign list_last = (link_rdata == END_MARK) || (pos_ff == LAST_POS);
   assign mid_pos   = (count_ff == '0) ? '0 : ((count_ff - IW'(1)) >> 1) + IW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_insert) begin
                  state_in = (count_ff >= END_MARK) ? ST_EMIT : ST_ALLOC;
               end else if ((req_data.kind == KIND_SEARCH) || (req_data.kind == KIND_REMOVE))
               begin
                  state_in = (head_ff == END_MARK) ? ST_EMIT : ST_WALK_FIND;
               end else if (req_data.kind == KIND_LIST) begin
                  state_in = (head_ff == END_MARK) ? ST_EMIT : ST_LIST;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ALLOC: begin
            state_in = (tgt_ff == '0) ? ST_EMIT : ST_WALK_INS;
         end
         ST_WALK_INS: begin
            if (pos_ff == tgt_ff - AW'(1)) begin
               state_in = ST_LINK_PREV;
            end
         end
         ST_LINK_PREV: state_in = ST_EMIT;
         ST_WALK_FIND: begin
            if (match) begin
               state_in = (kind_ff == KIND_REMOVE) ? ST_FREE_NODE : ST_EMIT;
            end else if (list_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_FREE_NODE: state_in = ST_EMIT;
         ST_LIST: begin
            if (can_load && list_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory commands
   always_comb begin
      head_in     = head_ff;
      free_in     = free_ff;
      fresh_in    = fresh_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      node_in     = node_ff;
      pos_in      = pos_ff;
      tgt_in      = tgt_ff;
      kind_in     = kind_ff;
      value_in    = value_ff;
      res_in      = res_ff;
      rd_addr     = cur_ff[AW-1:0];
      link_we     = 1'b0;
      link_waddr  = cur_ff[AW-1:0];
      link_wdata  = free_ff;
      value_we    = 1'b0;
      value_waddr = node_ff[AW-1:0];
      value_wdata = value_ff;
      out_load    = 1'b0;
      out_word    = res_ff;
      out_word.count = 7'(count_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_data.kind;
               value_in = req_data.value;
               res_in   = '{status: STAT_OK, position: '0, element: '0, count: '0,
                            is_last: 1'b1};
               cur_in   = head_ff;
               prev_in  = END_MARK;
               pos_in   = '0;
               node_in  = free_ff;
               if (is_insert) begin
                  rd_addr = free_ff[AW-1:0];
                  if (count_ff >= END_MARK) begin
                     res_in.status = STAT_FULL;
                  end
                  if (req_data.kind == KIND_INS_HEAD) begin
                     tgt_in = '0;
                  end else if (req_data.kind == KIND_INS_MID) begin
                     tgt_in = mid_pos[AW-1:0];
                  end else begin
                     tgt_in = count_ff[AW-1:0];
                  end
               end else if ((req_data.kind == KIND_SEARCH) || (req_data.kind == KIND_REMOVE)
                            || (req_data.kind == KIND_LIST)) begin
                  rd_addr = head_ff[AW-1:0];
                  if (head_ff == END_MARK) begin
                     res_in.status = STAT_EMPTY;
                  end
               end else if (head_ff == END_MARK) begin
                  res_in.status = STAT_EMPTY;
               end
            end
         end
         ST_ALLOC: begin
            // untouched nodes still chain to their successor
            if (node_ff == fresh_ff) begin
               free_in  = node_ff + IW'(1);
               fresh_in = fresh_ff + IW'(1);
            end else begin
               free_in = link_rdata;
            end
            value_we = 1'b1;
            count_in = count_ff + IW'(1);
            if (tgt_ff == '0) begin
               link_we    = 1'b1;
               link_waddr = node_ff[AW-1:0];
               link_wdata = head_ff;
               head_in    = node_ff;
            end else begin
               rd_addr = head_ff[AW-1:0];
               cur_in  = head_ff;
            end
         end
         ST_WALK_INS: begin
            if (pos_ff == tgt_ff - AW'(1)) begin
               link_we    = 1'b1;
               link_waddr = node_ff[AW-1:0];
               link_wdata = link_rdata;
            end else begin
               cur_in  = link_rdata;
               rd_addr = link_rdata[AW-1:0];
               pos_in  = pos_ff + AW'(1);
            end
         end
         ST_LINK_PREV: begin
            link_we         = 1'b1;
            link_waddr      = cur_ff[AW-1:0];
            link_wdata      = node_ff;
            res_in.position = 6'(tgt_ff);
         end
         ST_WALK_FIND: begin
            if (match) begin
               res_in.position = 6'(pos_ff);
               res_in.element  = value_ff;
               if (kind_ff == KIND_REMOVE) begin
                  if (prev_ff == END_MARK) begin
                     head_in = link_rdata;
                  end else begin
                     link_we    = 1'b1;
                     link_waddr = prev_ff[AW-1:0];
                     link_wdata = link_rdata;
                  end
               end
            end else if (list_last) begin
               res_in.status = STAT_NOT_FOUND;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
               rd_addr = link_rdata[AW-1:0];
               pos_in  = pos_ff + AW'(1);
            end
         end
         ST_FREE_NODE: begin
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - IW'(1);
         end
         ST_LIST: begin
            out_word.status   = STAT_OK;
            out_word.position = 6'(pos_ff);
            out_word.element  = value_rdata;
            out_word.is_last  = list_last;
            if (can_load) begin
               out_load = 1'b1;
               cur_in   = link_rdata;
               rd_addr  = link_rdata[AW-1:0];
               pos_in   = pos_ff + AW'(1);
            end
         end
         ST_EMIT: begin
            out_load = can_load;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= END_MARK;
         free_ff  <= '0;
         fresh_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
         count_ff <= count_in;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      node_ff  <= node_in;
      pos_ff   <= pos_in;
      tgt_ff   <= tgt_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= END_MARK) else $error("element count above capacity");

   // the head moves in the cycle before the count drops on a remove
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FREE_NODE) |-> ((head_ff == END_MARK) == (count_ff == '0)))
      else $error("head and count disagree");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> can_load) else $error("result loaded into busy output");

   a_fresh_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |=> (fresh_ff >= $past(fresh_ff)))
      else $error("fresh node mark went back");

endmodule

### src/bounded_linked_list_engine.sv
// top level of the bounded linked list engine
//
//   channel  dir  handshake             word
//   req      in   req_valid/req_stall   req_data: kind, value
//   rsp      out  rsp_valid/rsp_stall   rsp_data: status, position, element, count, is_last
//
// an insert allocates a node, links it in at the head or walks to its position and
// links its predecessor; a search walks until a match or the list end, and a remove
// also unlinks and frees the matched node; a list sends one result word per element
// while rsp is not stalled; every node step is one read of the link and value memories
// reset clears head, free pointer, fresh node mark and count; no memory clearing
// pass is needed, nodes never handed out are treated as chained to their successor
// a stalled result waits in the output register; no new word is loaded until it drains
module bounded_linked_list_engine
   import bll_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   // shared read address for both node memories
   logic [AW-1:0] rd_addr;
   logic [IW-1:0] link_rdata;
   logic [31:0]   value_rdata;
   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [IW-1:0] link_wdata;
   logic          value_we;
   logic [AW-1:0] value_waddr;
   logic [31:0]   value_wdata;

   // output stage
   logic          can_load;
   logic          out_load;
   rsp_type       out_word;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // next-node links, end marker is one past the last node
   bll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   // node payload values
   bll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (value_waddr),
      .wr_data (value_wdata),
      .rd_addr (rd_addr),
      .rd_data (value_rdata)
   );

   bll_seq #(.CAPACITY(CAPACITY)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rd_addr     (rd_addr),
      .link_rdata  (link_rdata),
      .value_rdata (value_rdata),
      .link_we     (link_we),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .value_we    (value_we),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata),
      .can_load    (can_load),
      .out_load    (out_load),
      .out_word    (out_word)
   );

   // output register is free when empty or being drained this cycle
   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
